// ----- sv/v2r_pkg.sv -----
// Shared types, constants and the helper function of the v210 to RGB converter.
package v2r_pkg;

    localparam int CFG_W     = 13;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int WORD_W    = 32;
    localparam int SAMPLE_W  = 10;
    localparam int PIX_W     = 8;
    localparam int GROUP_PIX = 6;
    localparam int GROUP_CHR = 3;
    localparam int CNT_W     = 3;
    localparam int FRAC_W    = 10;
    localparam int SUM_W     = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam int MAX_LINE_PIXELS_DEF = 4096;
    localparam int MAX_FRAME_LINES_DEF = 4096;

    localparam logic [CFG_W-1:0] LINE_PIXELS_RST = 13'd1920;
    localparam logic [CFG_W-1:0] FRAME_LINES_RST = 13'd1080;

    localparam logic REG_LINE_PIXELS = 1'b0;
    localparam logic REG_FRAME_LINES = 1'b1;

    localparam int COEF_Y  = 1192;
    localparam int COEF_RV = 1634;
    localparam int COEF_GU = 401;
    localparam int COEF_GV = 833;
    localparam int COEF_BU = 2066;
    localparam int LUMA_OFS   = 64;
    localparam int CHROMA_OFS = 512;
    localparam int ROUND_OFS  = 512;
    localparam int PIX_MAX    = 255;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t [GROUP_PIX-1:0] y;
        sample_t [GROUP_CHR-1:0] cb;
        sample_t [GROUP_CHR-1:0] cr;
        logic [CNT_W-1:0]        count;
        logic                    rend;
        logic                    fend;
    } v2r_entry_t;

    function automatic logic [PIX_W-1:0] to_byte(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] sh;
        logic [PIX_W-1:0]        res;
        sh = s >>> FRAC_W;
        if (s < 0)
        begin
            res = '0;
        end
        else if (sh > SUM_W'(PIX_MAX))
        begin
            res = PIX_W'(PIX_MAX);
        end
        else
        begin
            res = sh[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/v2r_if.sv -----
// Stream channel interfaces for v210 group beats and RGB pixel beats.
interface v2r_grp_if
    import v2r_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] word_c;
    logic [WORD_W-1:0] word_d;

    modport source (output valid, word_a, word_b, word_c, word_d, input ready);
    modport sink (input valid, word_a, word_b, word_c, word_d, output ready);
endinterface

interface v2r_pix_if
    import v2r_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             group_last;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, red, green, blue, group_last, row_end, frame_end,
                    input ready);
    modport sink (input valid, red, green, blue, group_last, row_end, frame_end,
                  output ready);
endinterface

// ----- sv/v2r_front.sv -----
// Front end: accepts group beats, unpacks samples and tracks column and line position.
module v2r_front
    import v2r_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF,
    parameter int MAX_FRAME_LINES = MAX_FRAME_LINES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] line_pixels,
    input  logic [CFG_W-1:0] frame_lines,
    v2r_grp_if.sink          grp,
    input  logic             full,
    output logic             push,
    output v2r_entry_t       push_entry
);

    localparam int WID_W  = $clog2(MAX_LINE_PIXELS + 1);
    localparam int COL_W  = $clog2(MAX_LINE_PIXELS);
    localparam int HGT_W  = $clog2(MAX_FRAME_LINES + 1);
    localparam int LINE_W = (MAX_FRAME_LINES > 1) ? $clog2(MAX_FRAME_LINES) : 1;

    logic [COL_W-1:0]  column_reg, column_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [WID_W-1:0]  width;
    logic [HGT_W-1:0]  height;
    logic [COL_W-1:0]  col_eff;
    logic [LINE_W-1:0] ln_eff;
    logic [WID_W-1:0]  rem;
    logic              rend;
    logic              fend;

    always_comb
    begin
        if (line_pixels == '0)
        begin
            width = WID_W'(1);
        end
        else if (32'(line_pixels) > 32'(MAX_LINE_PIXELS))
        begin
            width = WID_W'(MAX_LINE_PIXELS);
        end
        else
        begin
            width = WID_W'(line_pixels);
        end

        if (frame_lines == '0)
        begin
            height = HGT_W'(1);
        end
        else if (32'(frame_lines) > 32'(MAX_FRAME_LINES))
        begin
            height = HGT_W'(MAX_FRAME_LINES);
        end
        else
        begin
            height = HGT_W'(frame_lines);
        end
    end

    always_comb
    begin
        col_eff = (32'(column_reg) >= 32'(width)) ? '0 : column_reg;
        ln_eff  = (32'(line_reg) >= 32'(height)) ? '0 : line_reg;
        rem     = width - WID_W'(col_eff);
        rend    = (32'(rem) <= 32'(GROUP_PIX));
        fend    = rend && ((32'(ln_eff) + 32'd1) == 32'(height));

        if (rend)
        begin
            column_next = '0;
            line_next   = fend ? '0 : ln_eff + LINE_W'(1);
        end
        else
        begin
            column_next = col_eff + COL_W'(GROUP_PIX);
            line_next   = ln_eff;
        end
    end

    assign grp.ready = !full;
    assign push      = grp.valid && !full;

    always_comb
    begin
        push_entry.cb[0] = grp.word_a[9:0];
        push_entry.y[0]  = grp.word_a[19:10];
        push_entry.cr[0] = grp.word_a[29:20];
        push_entry.y[1]  = grp.word_b[9:0];
        push_entry.cb[1] = grp.word_b[19:10];
        push_entry.y[2]  = grp.word_b[29:20];
        push_entry.cr[1] = grp.word_c[9:0];
        push_entry.y[3]  = grp.word_c[19:10];
        push_entry.cb[2] = grp.word_c[29:20];
        push_entry.y[4]  = grp.word_d[9:0];
        push_entry.cr[2] = grp.word_d[19:10];
        push_entry.y[5]  = grp.word_d[29:20];
        push_entry.count = rend ? CNT_W'(rem) : CNT_W'(GROUP_PIX);
        push_entry.rend  = rend;
        push_entry.fend  = fend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            line_reg   <= '0;
        end
        else if (push)
        begin
            column_reg <= column_next;
            line_reg   <= line_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_entry.count != '0) && (32'(push_entry.count) <= 32'(GROUP_PIX)))
        else $error("Group pixel count out of range.");

    a_full_group: assert property (@(posedge clk) disable iff (!rst_n)
        push && !push_entry.rend |-> 32'(push_entry.count) == 32'(GROUP_PIX))
        else $error("A group that does not end a line must yield six pixels.");

    a_frame_needs_row: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.fend |-> push_entry.rend && line_next == '0)
        else $error("Frame end without row end or line wrap.");

endmodule

// ----- sv/v2r_queue.sv -----
// Short queue of classified groups between the front end and the pixel back end.
module v2r_queue
    import v2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  v2r_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       valid,
    output v2r_entry_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    v2r_entry_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    assign full  = (32'(occ_reg) == 32'(QUEUE_DEPTH));
    assign valid = (occ_reg != '0);
    assign head  = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        occ_next  = occ_reg;
        if (push)
        begin
            wptr_next = (32'(wptr_reg) == QUEUE_DEPTH - 1) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (32'(rptr_reg) == QUEUE_DEPTH - 1) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (pop && !push)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            occ_reg  <= occ_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("Queue read while empty.");

    a_entry_kept: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !pop |=> valid)
        else $error("Queue entry lost without a read.");

endmodule

// ----- sv/v2r_back.sv -----
// Back end: steps through the pixels of a group and converts each one to RGB.
module v2r_back
    import v2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  v2r_entry_t q_entry,
    output logic       pop,
    v2r_pix_if.source  pix
);

    logic [CNT_W-1:0]        k_reg, k_next;
    logic                    s0_v_reg, s0_v_next;
    logic                    s1_v_reg, s1_v_next;
    logic                    o_v_reg, o_v_next;
    logic                    o_load, s1_load, s0_load;
    logic                    issue, last;

    sample_t                 y_sel, cb_sel, cr_sel;
    logic signed [SAMPLE_W:0] c_next, d_next, e_next;
    logic signed [SAMPLE_W:0] s0_c_reg, s0_d_reg, s0_e_reg;
    logic [2:0]              s0_flags_reg, s1_flags_reg, o_flags_reg;

    logic signed [SUM_W-1:0] s1_py_reg, s1_prv_reg, s1_pgu_reg, s1_pgv_reg, s1_pbu_reg;
    logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;
    logic [PIX_W-1:0]        o_red_reg, o_green_reg, o_blue_reg;

    assign o_load  = !o_v_reg || pix.ready;
    assign s1_load = !s1_v_reg || o_load;
    assign s0_load = !s0_v_reg || s1_load;
    assign issue   = q_valid && s0_load;
    assign last    = (k_reg == q_entry.count - CNT_W'(1));
    assign pop     = issue && last;

    always_comb
    begin
        k_next = k_reg;
        if (issue)
        begin
            k_next = last ? '0 : k_reg + CNT_W'(1);
        end
        s0_v_next = s0_load ? issue : s0_v_reg;
        s1_v_next = s1_load ? s0_v_reg : s1_v_reg;
        o_v_next  = o_load ? s1_v_reg : o_v_reg;
    end

    always_comb
    begin
        y_sel  = q_entry.y[k_reg];
        cb_sel = q_entry.cb[k_reg[CNT_W-1:1]];
        cr_sel = q_entry.cr[k_reg[CNT_W-1:1]];
        if (32'(y_sel) < 32'(LUMA_OFS))
        begin
            c_next = '0;
        end
        else
        begin
            c_next = $signed({1'b0, y_sel}) - (SAMPLE_W + 1)'(LUMA_OFS);
        end
        d_next = $signed({1'b0, cb_sel}) - (SAMPLE_W + 1)'(CHROMA_OFS);
        e_next = $signed({1'b0, cr_sel}) - (SAMPLE_W + 1)'(CHROMA_OFS);
    end

    always_comb
    begin
        sum_r = s1_py_reg + s1_prv_reg + SUM_W'(ROUND_OFS);
        sum_g = s1_py_reg - s1_pgu_reg - s1_pgv_reg + SUM_W'(ROUND_OFS);
        sum_b = s1_py_reg + s1_pbu_reg + SUM_W'(ROUND_OFS);
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s0_c_reg     <= c_next;
            s0_d_reg     <= d_next;
            s0_e_reg     <= e_next;
            s0_flags_reg <= {last, last && q_entry.rend, last && q_entry.fend};
        end
        if (s1_load && s0_v_reg)
        begin
            s1_py_reg    <= SUM_W'(s0_c_reg) * SUM_W'(COEF_Y);
            s1_prv_reg   <= SUM_W'(s0_e_reg) * SUM_W'(COEF_RV);
            s1_pgu_reg   <= SUM_W'(s0_d_reg) * SUM_W'(COEF_GU);
            s1_pgv_reg   <= SUM_W'(s0_e_reg) * SUM_W'(COEF_GV);
            s1_pbu_reg   <= SUM_W'(s0_d_reg) * SUM_W'(COEF_BU);
            s1_flags_reg <= s0_flags_reg;
        end
        if (o_load && s1_v_reg)
        begin
            o_red_reg   <= to_byte(sum_r);
            o_green_reg <= to_byte(sum_g);
            o_blue_reg  <= to_byte(sum_b);
            o_flags_reg <= s1_flags_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= '0;
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            k_reg    <= k_next;
            s0_v_reg <= s0_v_next;
            s1_v_reg <= s1_v_next;
            o_v_reg  <= o_v_next;
        end
    end

    assign pix.valid      = o_v_reg;
    assign pix.red        = o_red_reg;
    assign pix.green      = o_green_reg;
    assign pix.blue       = o_blue_reg;
    assign pix.group_last = o_flags_reg[2];
    assign pix.row_end    = o_flags_reg[1];
    assign pix.frame_end  = o_flags_reg[0];

    a_index_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> k_reg < q_entry.count)
        else $error("Pixel index beyond the group count.");

    a_index_rests: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> k_reg == '0)
        else $error("Pixel index not at zero between groups.");

    a_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.row_end |-> pix.group_last)
        else $error("Row end on a pixel that is not the last of its group.");

    a_frame_flags: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.frame_end |-> pix.row_end)
        else $error("Frame end without row end.");

endmodule

// ----- sv/v210_to_rgba_converter_unit.sv -----
// Top level of the v210 group to RGB pixel converter with its register port.
// Each accepted group beat is queued; its pixels then pass the s0, s1 and output registers.
// Throughput: one pixel per cycle while groups are queued and pix.ready is not held low;
// the single conversion pipeline in the back end sets this rate.
// Reset: rst_n clears column, line, queue and pipeline valid state; registers return
// to 1920 pixels per line and 1080 lines per frame.
module v210_to_rgba_converter_unit
    import v2r_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF,
    parameter int MAX_FRAME_LINES = MAX_FRAME_LINES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    v2r_grp_if.sink           grp,
    v2r_pix_if.source         pix
);

    logic [CFG_W-1:0] line_pixels_reg, line_pixels_next;
    logic [CFG_W-1:0] frame_lines_reg, frame_lines_next;
    logic             wr_en;
    logic             push, pop, full, q_valid;
    v2r_entry_t       push_entry, q_entry;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        line_pixels_next = line_pixels_reg;
        frame_lines_next = frame_lines_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_LINE_PIXELS: line_pixels_next = pwdata[CFG_W-1:0];
                REG_FRAME_LINES: frame_lines_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LINE_PIXELS: prdata = APB_DW'(line_pixels_reg);
            REG_FRAME_LINES: prdata = APB_DW'(frame_lines_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pixels_reg <= LINE_PIXELS_RST;
            frame_lines_reg <= FRAME_LINES_RST;
        end
        else
        begin
            line_pixels_reg <= line_pixels_next;
            frame_lines_reg <= frame_lines_next;
        end
    end

    v2r_front #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .MAX_FRAME_LINES (MAX_FRAME_LINES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_pixels (line_pixels_reg),
        .frame_lines (frame_lines_reg),
        .grp         (grp),
        .full        (full),
        .push        (push),
        .push_entry  (push_entry)
    );

    v2r_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .valid      (q_valid),
        .head       (q_entry)
    );

    v2r_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .pix     (pix)
    );

endmodule
